// File: design/mpbm_pkg.sv
// Shared types and constants for the multi-pattern byte matcher.
package mpbm_pkg;

    // Field widths of the item and result ports.
    localparam int FUNC_W = 2;
    localparam int BYTE_W = 8;
    localparam int PIDX_W = 4;
    localparam int CPOS_W = 5;
    localparam int PLEN_W = 6;
    localparam int NPAT_W = 5;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_SEARCH    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_BYTE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_LENGTH = 2'd2;

    // Command broadcast from the top level to every cell, already qualified by acceptance.
    typedef struct packed {
        logic              search;
        logic              sob;
        logic              wr_byte;
        logic              wr_len;
        logic [BYTE_W-1:0] data_byte;
        logic [PIDX_W-1:0] pattern_index;
        logic [CPOS_W-1:0] char_position;
        logic [PLEN_W-1:0] pattern_length;
    } mpbm_cmd_t;

    // Priority chain between neighboring cells: the lowest completed pattern so far.
    typedef struct packed {
        logic              found;
        logic [PIDX_W-1:0] pattern;
        logic [PLEN_W-1:0] length;
    } mpbm_chain_t;

endpackage

// File: design/mpbm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read at the written address returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mpbm_cell.sv
// One pattern cell: stored pattern, length, progress counter and its link in the priority chain.
module mpbm_cell
    import mpbm_pkg::*;
#(
    parameter int INDEX           = 0,
    parameter int MAX_PATTERN_LEN = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mpbm_cmd_t         cmd,
    input  logic [NPAT_W-1:0] num_patterns,
    input  mpbm_chain_t       chain_in,
    output mpbm_chain_t       chain_out
);

    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_PATTERN_LEN);

    logic [ADDR_W-1:0] counter_reg, counter_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [BYTE_W-1:0] first_reg, first_next;
    logic              bypass_reg, bypass_next;
    logic [BYTE_W-1:0] bypass_data_reg, bypass_data_next;
    logic [BYTE_W-1:0] ram_rdata;

    logic              hit;
    logic              byte_write;
    logic [ADDR_W-1:0] wr_addr;
    logic              participate;
    logic [LEN_W-1:0]  base;
    logic [LEN_W-1:0]  pos_next;
    logic [BYTE_W-1:0] expected;
    logic              complete;

    // Address decode for write transactions.
    assign hit        = (int'(cmd.pattern_index) == INDEX);
    assign byte_write = cmd.wr_byte && hit && (int'(cmd.char_position) < MAX_PATTERN_LEN);
    assign wr_addr    = ADDR_W'(cmd.char_position);

    // Compare the search byte with the next expected pattern byte.
    always_comb
    begin
        participate = cmd.search && (int'(num_patterns) > INDEX) && (length_reg != '0)
                      && !chain_in.found;
        base        = cmd.sob ? '0 : LEN_W'(counter_reg);
        if (cmd.sob)
        begin
            expected = first_reg;
        end
        else if (bypass_reg)
        begin
            expected = bypass_data_reg;
        end
        else
        begin
            expected = ram_rdata;
        end
        pos_next = (expected == cmd.data_byte) ? base + LEN_W'(1) : '0;
        complete = participate && (pos_next >= length_reg);
    end

    // Next state of the counter, length and prefetch bypass.
    always_comb
    begin
        counter_next     = counter_reg;
        length_next      = length_reg;
        first_next       = first_reg;
        bypass_next      = 1'b0;
        bypass_data_next = bypass_data_reg;
        if (cmd.search && cmd.sob)
        begin
            counter_next = '0;
        end
        if (participate)
        begin
            counter_next = complete ? '0 : ADDR_W'(pos_next);
        end
        if (cmd.wr_len && hit)
        begin
            counter_next = '0;
            if (int'(cmd.pattern_length) > MAX_PATTERN_LEN)
            begin
                length_next = LEN_W'(MAX_PATTERN_LEN);
            end
            else
            begin
                length_next = LEN_W'(cmd.pattern_length);
            end
        end
        if (byte_write)
        begin
            if (wr_addr == '0)
            begin
                first_next = cmd.data_byte;
            end
            if (wr_addr == counter_next)
            begin
                bypass_next      = 1'b1;
                bypass_data_next = cmd.data_byte;
            end
        end
    end

    // Pass on an earlier completion, otherwise report this pattern if it completed.
    always_comb
    begin
        chain_out = chain_in;
        if (complete)
        begin
            chain_out.found   = 1'b1;
            chain_out.pattern = PIDX_W'(INDEX);
            chain_out.length  = PLEN_W'(length_reg);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            length_reg  <= '0;
            bypass_reg  <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            length_reg  <= length_next;
            bypass_reg  <= bypass_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        first_reg       <= first_next;
        bypass_data_reg <= bypass_data_next;
    end

    // Pattern bytes; the read address follows the counter so the next expected byte is ready.
    mpbm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PATTERN_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (byte_write),
        .waddr (wr_addr),
        .wdata (cmd.data_byte),
        .raddr (counter_next),
        .rdata (ram_rdata)
    );

endmodule

// File: design/multi_pattern_byte_matcher_core.sv
// Multi-pattern byte matcher: a chain of pattern cells with an output register.
//
// The block takes one transaction per clock cycle unless the input is stalled, and returns
// exactly one result per transaction from its output register. Throughput is one byte per cycle:
// every pattern cell compares the byte against its next expected character in parallel, and
// the completion with the lowest index is selected by a ripple priority chain through the
// cells, which sets the critical path. Each cell keeps its pattern in a small RAM whose read
// address follows the progress counter, so the next expected character is already read when
// the byte arrives; a separate copy of the first character serves the start of a buffer.
// Write transactions (pattern bytes and lengths) return a result with all fields zero. A
// length of zero disables a pattern. The num_patterns register must be written while the
// block is idle. There is no clearing pass after reset: pattern bytes are undefined until
// written, lengths and counters reset to zero. The input is stalled only while a result is
// held by a stalled output.
module multi_pattern_byte_matcher_core
    import mpbm_pkg::*;
#(
    parameter int MAX_PATTERNS    = 16,
    parameter int MAX_PATTERN_LEN = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [NPAT_W-1:0] cfg_write_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic              start_of_buffer,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [PIDX_W-1:0] pattern_index,
    input  logic [CPOS_W-1:0] char_position,
    input  logic [PLEN_W-1:0] pattern_length,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              match_found,
    output logic [PIDX_W-1:0] matched_pattern,
    output logic [PLEN_W-1:0] matched_length
);

    logic [NPAT_W-1:0] num_patterns_reg;
    logic              out_valid_reg, out_valid_next;
    mpbm_chain_t       result_reg, result_next;
    logic              accept;
    mpbm_cmd_t         cmd;
    mpbm_chain_t       chain [0:MAX_PATTERNS];

    // Handshake: hold the input only while a finished result is stalled.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Decode the function code into the command broadcast to the cells.
    always_comb
    begin
        cmd                = '0;
        cmd.sob            = start_of_buffer;
        cmd.data_byte      = data_byte;
        cmd.pattern_index  = pattern_index;
        cmd.char_position  = char_position;
        cmd.pattern_length = pattern_length;
        unique case (func)
            FUNC_SEARCH:    cmd.search  = accept;
            FUNC_WR_BYTE:   cmd.wr_byte = accept;
            FUNC_WR_LENGTH: cmd.wr_len  = accept;
            default:        cmd.search  = 1'b0;
        endcase
    end

    // Row of pattern cells linked by the priority chain.
    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_PATTERNS; i++)
    begin : g_cell
        mpbm_cell #(
            .INDEX           (i),
            .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .num_patterns (num_patterns_reg),
            .chain_in     (chain[i]),
            .chain_out    (chain[i+1])
        );
    end

    // Output register: a search reports the chain's result, any other transaction zeros.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            result_next    = cmd.search ? chain[MAX_PATTERNS] : '0;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_patterns_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                num_patterns_reg <= cfg_write_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign match_found     = result_reg.found;
    assign matched_pattern = result_reg.pattern;
    assign matched_length  = result_reg.length;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for multi_pattern_byte_matcher_core with a built-in match predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mpbm_pkg::*;

    localparam int MAX_PATTERNS    = 16;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int STALL_LIMIT     = 5000;
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    // One input transaction, one field per port.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              sob;
        logic [BYTE_W-1:0] data;
        logic [PIDX_W-1:0] pidx;
        logic [CPOS_W-1:0] cpos;
        logic [PLEN_W-1:0] plen;
    } scan_cmd_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_write_en = 1'b0;
    logic [NPAT_W-1:0] cfg_write_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    scan_cmd_t         cur_cmd = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              match_found;
    logic [PIDX_W-1:0] matched_pattern;
    logic [PLEN_W-1:0] matched_length;
    logic              in_fire = 1'b0;

    scan_cmd_t   pending_cmds[$];
    mpbm_chain_t expected_matches[$];
    int          send_idle_pct = 10;
    int          recv_stall_pct = 57;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          staged_count = 0;

    // Predictor copy of the matcher state.
    logic [PLEN_W-1:0] pred_count [MAX_PATTERNS];
    logic [BYTE_W-1:0] pred_bytes [MAX_PATTERNS][MAX_PATTERN_LEN];
    logic [PLEN_W-1:0] pred_len [MAX_PATTERNS];
    logic [NPAT_W-1:0] pred_npat;

    // What the stimulus side knows of the stored patterns, in staging order.
    logic [BYTE_W-1:0] gen_bytes [MAX_PATTERNS][MAX_PATTERN_LEN];
    bit                gen_written [MAX_PATTERNS][MAX_PATTERN_LEN];
    int                gen_len [MAX_PATTERNS];
    int                gen_active;

    multi_pattern_byte_matcher_core #(
        .MAX_PATTERNS   (MAX_PATTERNS),
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (cur_cmd.func),
        .start_of_buffer(cur_cmd.sob),
        .data_byte      (cur_cmd.data),
        .pattern_index  (cur_cmd.pidx),
        .char_position  (cur_cmd.cpos),
        .pattern_length (cur_cmd.plen),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_found    (match_found),
        .matched_pattern(matched_pattern),
        .matched_length (matched_length)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Expected result of one transaction; updates the predictor state.
    function automatic mpbm_chain_t predict_match(scan_cmd_t c);
        mpbm_chain_t r;
        int          active;
        int          pos;
        int          i;
        r = '0;
        case (c.func)
            FUNC_SEARCH:
            begin
                active = (pred_npat > MAX_PATTERNS) ? MAX_PATTERNS : int'(pred_npat);
                if (c.sob)
                    for (i = 0; i < MAX_PATTERNS; i++)
                        pred_count[i] = '0;
                // Priority scan: the first completion stops the walk.
                for (i = 0; i < active && !r.found; i++)
                begin
                    if (pred_len[i] != 0)
                    begin
                        pos = int'(pred_count[i]);
                        if (pos < MAX_PATTERN_LEN && pred_bytes[i][pos] == c.data)
                            pos++;
                        else
                            pos = 0;
                        if (pos >= pred_len[i])
                        begin
                            pred_count[i] = '0;
                            r.found       = 1'b1;
                            r.pattern     = PIDX_W'(i);
                            r.length      = pred_len[i];
                        end
                        else
                            pred_count[i] = PLEN_W'(pos);
                    end
                end
            end
            FUNC_WR_BYTE:
            begin
                if (c.pidx < MAX_PATTERNS && c.cpos < MAX_PATTERN_LEN)
                    pred_bytes[c.pidx][c.cpos] = c.data;
            end
            FUNC_WR_LENGTH:
            begin
                if (c.pidx < MAX_PATTERNS)
                begin
                    pred_len[c.pidx]   = (c.plen > MAX_PATTERN_LEN) ?
                                         PLEN_W'(MAX_PATTERN_LEN) : c.plen;
                    pred_count[c.pidx] = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Transaction of the given operation with every other field random.
    function automatic scan_cmd_t random_cmd(logic [FUNC_W-1:0] f);
        scan_cmd_t c;
        c.func = f;
        c.sob  = 1'($urandom_range(1));
        c.data = BYTE_W'($urandom);
        c.pidx = PIDX_W'($urandom);
        c.cpos = CPOS_W'($urandom);
        c.plen = PLEN_W'($urandom);
        return c;
    endfunction

    function automatic scan_cmd_t search_cmd(logic sob, logic [BYTE_W-1:0] b);
        scan_cmd_t c;
        c      = random_cmd(FUNC_SEARCH);
        c.sob  = sob;
        c.data = b;
        return c;
    endfunction

    function automatic scan_cmd_t write_byte_cmd(int p, int pos, logic [BYTE_W-1:0] b);
        scan_cmd_t c;
        c      = random_cmd(FUNC_WR_BYTE);
        c.pidx = PIDX_W'(p);
        c.cpos = CPOS_W'(pos);
        c.data = b;
        return c;
    endfunction

    function automatic scan_cmd_t length_cmd(int p, int len);
        scan_cmd_t c;
        c      = random_cmd(FUNC_WR_LENGTH);
        c.pidx = PIDX_W'(p);
        c.plen = PLEN_W'(len);
        return c;
    endfunction

    // Bytes mostly from a small alphabet so that patterns overlap and recur.
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(9) < 6)
            case ($urandom_range(3))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h5A;
                default: b = 8'hA5;
            endcase
        else
            b = BYTE_W'($urandom);
        return b;
    endfunction

    // Queue a transaction and track what it stores.
    function automatic void stage_cmd(scan_cmd_t c);
        if (c.func == FUNC_WR_BYTE)
        begin
            gen_bytes[c.pidx][c.cpos]   = c.data;
            gen_written[c.pidx][c.cpos] = 1'b1;
        end
        else if (c.func == FUNC_WR_LENGTH)
            gen_len[c.pidx] = (c.plen > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(c.plen);
        pending_cmds.push_back(c);
        staged_count++;
    endfunction

    // A length write, preceded by writes of any pattern byte it would expose unwritten.
    function automatic void stage_length(int p, int len);
        int eff;
        int k;
        eff = (len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len;
        for (k = 0; k < eff; k++)
            if (!gen_written[p][k])
                stage_cmd(write_byte_cmd(p, k, pick_byte()));
        stage_cmd(length_cmd(p, len));
    endfunction

    // A stored pattern sent as search bytes, sometimes cut short or corrupted.
    function automatic void stage_pattern_run();
        int p;
        int n;
        int t;
        int k;
        int cut;
        int bad;
        p = -1;
        if (gen_active == 0)
        begin
            stage_cmd(search_cmd(1'b0, pick_byte()));
            return;
        end
        for (t = 0; t < 8 && p < 0; t++)
        begin
            n = $urandom_range(gen_active - 1);
            if (gen_len[n] != 0)
                p = n;
        end
        if (p < 0)
        begin
            p = $urandom_range(gen_active - 1);
            stage_length(p, $urandom_range(6, 1));
        end
        repeat ($urandom_range(2))
            stage_cmd(search_cmd(1'b0, pick_byte()));
        cut = gen_len[p];
        bad = -1;
        case ($urandom_range(9))
            0: cut = $urandom_range(gen_len[p] - 1);
            1: bad = $urandom_range(gen_len[p] - 1);
            default: ;
        endcase
        for (k = 0; k < cut; k++)
            stage_cmd(search_cmd(k == 0 && $urandom_range(2) == 0,
                                 (k == bad) ? pick_byte() : gen_bytes[p][k]));
    endfunction

    // Random mix of pattern runs, noise, pattern updates and unknown operations.
    function automatic void stage_random(int n);
        int first;
        int r;
        int s;
        int len;
        first = staged_count;
        while (staged_count - first < n)
        begin
            r = $urandom_range(99);
            if (r < 60)
                stage_pattern_run();
            else if (r < 75)
                stage_cmd(search_cmd($urandom_range(9) == 0, pick_byte()));
            else if (r < 85)
            begin
                s = $urandom_range(9);
                if (s < 7)
                    len = $urandom_range(6, 1);
                else if (s == 7)
                    len = 0;
                else if (s == 8)
                    len = MAX_PATTERN_LEN;
                else
                    len = $urandom_range(63, MAX_PATTERN_LEN + 1);
                stage_length($urandom_range(MAX_PATTERNS - 1), len);
            end
            else if (r < 95)
                stage_cmd(write_byte_cmd($urandom_range(MAX_PATTERNS - 1),
                                         $urandom_range(MAX_PATTERN_LEN - 1), pick_byte()));
            else
                stage_cmd(random_cmd(FUNC_UNKNOWN));
        end
    endfunction

    // Block until every queued transaction has been accepted and answered.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || expected_matches.size() != 0)
            @(negedge clk);
    endtask

    // Register write, only while the matcher is idle.
    task automatic set_num_patterns(logic [NPAT_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        pred_npat  = v;
        gen_active = (v > MAX_PATTERNS) ? MAX_PATTERNS : int'(v);
    endtask

    // One setting of the register and the idle rates; pauses halfway until all results are in.
    task automatic run_phase(logic [NPAT_W-1:0] npat, int sp, int rp, int n);
        send_idle_pct  = sp;
        recv_stall_pct = rp;
        set_num_patterns(npat);
        stage_random(n / 2);
        wait_drained();
        stage_random(n - n / 2);
    endtask

    task automatic check_field(string what, int expv, int actv);
        if (expv != actv)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, what, expv, actv);
            mismatch_count++;
        end
    endtask

    // Driver: new transaction or idle cycle at the falling edge; random output stall.
    always @(negedge clk)
    begin
        scan_cmd_t nxt;
        logic      nv;
        nxt = cur_cmd;
        nv  = in_valid;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_cmds.pop_front();
                nv  = 1'b1;
            end
            else
                nv = 1'b0;
        end
        cur_cmd   <= nxt;
        in_valid  <= nv;
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: check results, predict accepted transactions, count cycles without progress.
    always @(posedge clk)
    begin
        mpbm_chain_t exp_r;
        logic        busy;
        logic        moved;
        if (!rst_n)
        begin
            in_fire     <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (expected_matches.size() == 0)
                begin
                    $display("%0t ns: unexpected result found=%0d pattern=%0d length=%0d",
                             $time, match_found, matched_pattern, matched_length);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_matches.pop_front();
                    check_field("match_found", int'(exp_r.found), int'(match_found));
                    check_field("matched_pattern", int'(exp_r.pattern),
                                int'(matched_pattern));
                    check_field("matched_length", int'(exp_r.length), int'(matched_length));
                end
            end
            if (in_valid && !in_stall)
                expected_matches.push_back(predict_match(cur_cmd));
            moved = (in_valid && !in_stall) || (out_valid && !out_stall);
            busy  = pending_cmds.size() != 0 || in_valid || expected_matches.size() != 0;
            if (moved || !busy)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on a stuck handshake.
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("multi_pattern_byte_matcher_core regression: fail");
        $finish;
    end

    // Test sequence.
    initial
    begin
        for (int i = 0; i < MAX_PATTERNS; i++)
        begin
            pred_count[i] = '0;
            pred_len[i]   = '0;
            gen_len[i]    = 0;
            for (int k = 0; k < MAX_PATTERN_LEN; k++)
            begin
                pred_bytes[i][k]  = '0;
                gen_bytes[i][k]   = '0;
                gen_written[i][k] = 1'b0;
            end
        end
        pred_npat  = '0;
        gen_active = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: two-byte pattern 0 and one-byte pattern 15.
        set_num_patterns(NPAT_W'(MAX_PATTERNS));
        stage_cmd(write_byte_cmd(0, 0, 8'h00));
        stage_cmd(write_byte_cmd(0, 1, 8'hFF));
        stage_cmd(length_cmd(0, 2));
        stage_cmd(write_byte_cmd(15, 0, 8'hFF));
        stage_cmd(write_byte_cmd(15, MAX_PATTERN_LEN - 1, 8'hA5));
        stage_cmd(length_cmd(15, 1));
        // Pattern 0 completes first, so pattern 15 is left alone on that byte.
        stage_cmd(search_cmd(1'b1, 8'h00));
        stage_cmd(search_cmd(1'b0, 8'hFF));
        stage_cmd(search_cmd(1'b0, 8'hFF));
        // A mismatch is not retried against the first character.
        stage_cmd(search_cmd(1'b0, 8'h00));
        stage_cmd(search_cmd(1'b0, 8'h00));
        stage_cmd(search_cmd(1'b0, 8'hFF));
        // Start of buffer drops partial progress.
        stage_cmd(search_cmd(1'b0, 8'h00));
        stage_cmd(search_cmd(1'b1, 8'hFF));
        stage_cmd(random_cmd(FUNC_UNKNOWN));
        // Rewriting a length clears its progress; length zero disables the pattern.
        stage_cmd(search_cmd(1'b0, 8'h00));
        stage_cmd(length_cmd(0, 2));
        stage_cmd(search_cmd(1'b0, 8'hFF));
        stage_cmd(length_cmd(0, 0));
        stage_cmd(search_cmd(1'b0, 8'h00));
        stage_cmd(search_cmd(1'b0, 8'hFF));

        // Random phases over several register settings and idle profiles.
        run_phase(5'd16, 10, 57, 280);
        run_phase(5'd0, 10, 57, 100);
        run_phase(5'd31, 57, 10, 300);
        run_phase(5'd5, 57, 10, 250);
        run_phase(5'd1, 0, 0, 250);
        run_phase(5'd16, 0, 0, 300);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("multi_pattern_byte_matcher_core regression: pass");
        else
            $display("multi_pattern_byte_matcher_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/mpbm_pkg.sv
design/mpbm_ram.sv
design/mpbm_cell.sv
design/multi_pattern_byte_matcher_core.sv
tb/testbench.sv
